### sv/mchb_pkg.sv
// Shared types, widths and codes for the multi-click / hold button detector.
// No dependencies; imported by every module of the block.
package mchb_pkg;

  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 8;
  localparam int MS_BITS    = 16;
  localparam int REPORT_BITS = 8;
  localparam int CFG_IDX_BITS = 3;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_BITS  = ((TIME_BITS + 1 + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((REPORT_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic {
    REQ_EDGE = 1'b0,
    REQ_POLL = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_CLICK   = 2'd1,
    EV_HOLD    = 2'd2,
    EV_RELEASE = 2'd3
  } event_kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ACTIVE_HIGH = 3'd0,
    CFG_SILENCE     = 3'd1,
    CFG_RESTART     = 3'd2,
    CFG_HOLD        = 3'd3,
    CFG_REPORT_WAIT = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic               active_high;
    logic [MS_BITS-1:0] silence_ms;
    logic [MS_BITS-1:0] restart_ms;
    logic [MS_BITS-1:0] hold_ms;
    logic [MS_BITS-1:0] report_wait_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]  last_edge_time;
    logic [COUNT_BITS-1:0] clicks;
    logic                  holding;
  } state_t;

  typedef struct packed {
    event_kind_t            kind;
    logic [REPORT_BITS-1:0] count;
  } result_t;

  // reported count saturates at the width of the output field
  function automatic logic [REPORT_BITS-1:0] report_count(logic [COUNT_BITS-1:0] c);
    logic [REPORT_BITS-1:0] r;
    if (32'(c) > 32'((1 << REPORT_BITS) - 1)) begin
      r = '1;
    end else begin
      r = REPORT_BITS'(c);
    end
    return r;
  endfunction

endpackage

### sv/mchb_step.sv
// Per-item decision logic: next state and result from current state and one request.
// Depends on mchb_pkg.
module mchb_step (
  input  mchb_pkg::cfg_t                     cfg,
  input  mchb_pkg::state_t                   st,
  input  mchb_pkg::req_type_t                req_type,
  input  logic [mchb_pkg::TIME_BITS-1:0]     now_ms,
  input  logic                               pin_level,
  output mchb_pkg::state_t                   st_next,
  output mchb_pkg::result_t                  res
);
  import mchb_pkg::*;

  logic [TIME_BITS-1:0]  delta;
  logic                  pressed;
  logic                  h;
  logic [COUNT_BITS-1:0] c;
  logic [TIME_BITS-1:0]  last;
  event_kind_t           kind;
  logic [REPORT_BITS-1:0] count;

  assign delta   = now_ms - st.last_edge_time;
  assign pressed = (pin_level == cfg.active_high);

  always_comb begin
    h     = st.holding;
    c     = st.clicks;
    last  = st.last_edge_time;
    kind  = EV_NONE;
    count = '0;

    unique case (req_type)
      REQ_EDGE: begin
        // every edge moves the timestamp, bounces included
        last = now_ms;
        if (delta >= TIME_BITS'(cfg.silence_ms)) begin
          if (pressed) begin
            if (delta > TIME_BITS'(cfg.restart_ms)) begin
              c = '0;
            end
          end else if (!h) begin
            if (c != COUNT_MAX) c = c + 1'b1;
          end
        end
      end
      REQ_POLL: begin
        priority if (!h && pressed && delta >= TIME_BITS'(cfg.hold_ms)) begin
          h = 1'b1;
          if (c != COUNT_MAX) c = c + 1'b1;
        end else if (c != '0 && !h && delta >= TIME_BITS'(cfg.restart_ms)) begin
          c = '0;
        end else if (h && !pressed) begin
          kind  = EV_RELEASE;
          count = report_count(c);
          h     = 1'b0;
          c     = '0;
        end

        if (h) begin
          kind  = EV_HOLD;
          count = report_count(c);
        end else if (c != '0 && delta > TIME_BITS'(cfg.report_wait_ms)) begin
          kind  = EV_CLICK;
          count = report_count(c);
          c     = '0;
        end
      end
      default: ;
    endcase

    st_next.last_edge_time = last;
    st_next.clicks         = c;
    st_next.holding        = h;
    res.kind               = kind;
    res.count              = count;
  end

endmodule

### sv/multi_click_hold_button_detector.sv
// Top level of the multi-click / hold button detector: config registers, state, output buffer.
// Depends on mchb_pkg and mchb_step.
//
// Each request (a pin-change edge or a periodic poll, with timestamp and raw pin level)
// gives exactly one result: an event kind and a click count. A request is taken every
// cycle while input ready is high; its result is registered. The decision is a single pass
// of subtract-and-compare logic on the 32-bit timestamp difference, done as the request is
// taken, so state is ready for the next request in the very next cycle. A one-entry skid
// register behind the output lets the input accept one more request while the output is
// stalled; input ready drops only while the skid entry is full.
// Config writes are accepted every cycle and should be made only while the block is idle.
module multi_click_hold_button_detector (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [31:0] now_ms, [32] pin_level, rest zero
  input  logic [mchb_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
  // [0] req_type
  input  logic                                   s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // [7:0] click_count
  output logic [mchb_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
  // [1:0] event_kind
  output logic [1:0]                             m_axis_tuser,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mchb_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [mchb_pkg::MS_BITS-1:0]           cfg_data
);
  import mchb_pkg::*;

  cfg_t      cfg;
  state_t    st;
  state_t    st_next;
  result_t   res;
  result_t   out_res;
  result_t   skid_res;
  logic      out_valid;
  logic      skid_valid;
  logic      in_acc;
  logic      out_take;
  req_type_t req_type;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !skid_valid;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_take      = out_valid && m_axis_tready;
  assign req_type      = req_type_t'(s_axis_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_high    <= 1'b1;
      cfg.silence_ms     <= MS_BITS'(50);
      cfg.restart_ms     <= MS_BITS'(1000);
      cfg.hold_ms        <= MS_BITS'(800);
      cfg.report_wait_ms <= MS_BITS'(400);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ACTIVE_HIGH: cfg.active_high    <= cfg_data[0];
        CFG_SILENCE:     cfg.silence_ms     <= cfg_data;
        CFG_RESTART:     cfg.restart_ms     <= cfg_data;
        CFG_HOLD:        cfg.hold_ms        <= cfg_data;
        CFG_REPORT_WAIT: cfg.report_wait_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  mchb_step u_step (
    .cfg       (cfg),
    .st        (st),
    .req_type  (req_type),
    .now_ms    (s_axis_tdata[TIME_BITS-1:0]),
    .pin_level (s_axis_tdata[TIME_BITS]),
    .st_next   (st_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_take) begin
      if (in_acc) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_take) begin
      if (in_acc) skid_res <= res;
    end else if (skid_valid) begin
      out_res <= skid_res;
    end else if (in_acc) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = OUT_TDATA_BITS'(out_res.count);

endmodule

### sv/mchb_checker.sv
// Port-level checks for the multi-click / hold button detector, bound to the top level.
// Depends on mchb_pkg and multi_click_hold_button_detector.
module mchb_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [mchb_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  input logic [1:0]                          m_axis_tuser
);
  import mchb_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == EV_NONE |-> m_axis_tdata == '0)
    else $error("no-event result carries a count");

  a_click_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == EV_CLICK |-> m_axis_tdata != '0)
    else $error("click report with zero count");

  // input back-pressure only happens with a result waiting
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with output empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("buffers not empty after reset");

endmodule

bind multi_click_hold_button_detector mchb_checker u_mchb_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### tb/tb_multi_click_hold_button_detector.sv
// Self-checking testbench for multi_click_hold_button_detector: stream requests in, one result out.
// Depends on mchb_pkg and the RTL; a scoreboard class tracks button state and expected results.
module tb_multi_click_hold_button_detector;
  import mchb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    event_kind_t kind;
    logic [7:0]  count;
  } outcome_t;

  class click_scoreboard;
    bit          active_high;
    logic [15:0] silence_ms;
    logic [15:0] restart_ms;
    logic [15:0] hold_ms;
    logic [15:0] report_wait_ms;
    logic [31:0] last_edge;
    logic [7:0]  clicks;
    bit          holding;
    outcome_t    due[$];
    int          errors;

    function new();
      active_high    = 1'b1;
      silence_ms     = 16'd50;
      restart_ms     = 16'd1000;
      hold_ms        = 16'd800;
      report_wait_ms = 16'd400;
      last_edge      = '0;
      clicks         = '0;
      holding        = 1'b0;
      errors         = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [15:0] value);
      case (idx)
        CFG_ACTIVE_HIGH: active_high    = value[0];
        CFG_SILENCE:     silence_ms     = value;
        CFG_RESTART:     restart_ms     = value;
        CFG_HOLD:        hold_ms        = value;
        CFG_REPORT_WAIT: report_wait_ms = value;
        default: ;
      endcase
    endfunction

    function void add_click();
      if (clicks != 8'hFF) clicks++;
    endfunction

    // works out the outcome of one accepted request and queues it
    function void note_request(req_type_t rt, logic [31:0] now, bit pin);
      logic [31:0] delta;
      bit          pressed;
      outcome_t    o;
      pressed = (pin == active_high);
      delta   = now - last_edge;
      o.kind  = EV_NONE;
      o.count = '0;
      if (rt == REQ_EDGE) begin
        last_edge = now;
        if (delta >= {16'b0, silence_ms}) begin
          if (pressed) begin
            // long quiet before a press: start the count over
            if (delta > {16'b0, restart_ms}) clicks = '0;
          end else if (!holding) begin
            add_click();
          end
        end
      end else begin
        if (!holding && pressed && delta >= {16'b0, hold_ms}) begin
          holding = 1'b1;
          add_click();
        end else if (clicks != 0 && !holding && delta >= {16'b0, restart_ms}) begin
          clicks = '0;
        end else if (holding && !pressed) begin
          o.kind  = EV_RELEASE;
          o.count = clicks;
          holding = 1'b0;
          clicks  = '0;
        end
        if (holding) begin
          o.kind  = EV_HOLD;
          o.count = clicks;
        end else if (clicks != 0 && delta > {16'b0, report_wait_ms}) begin
          o.kind  = EV_CLICK;
          o.count = clicks;
          clicks  = '0;
        end
      end
      due.push_back(o);
    endfunction

    task report_mismatch(string what);
      if (errors < 50) $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_result(event_kind_t kind, logic [7:0] count);
      outcome_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d count=%0d", kind, count));
      end else begin
        want = due.pop_front();
        if (want.kind !== kind || want.count !== count)
          report_mismatch($sformatf("kind=%0d count=%0d, wanted kind=%0d count=%0d",
                                    kind, count, want.kind, want.count));
      end
    endtask

    function int pending();
      return due.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [IN_TDATA_BITS-1:0]  s_axis_tdata;
  logic                      s_axis_tuser;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b1;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic [1:0]                m_axis_tuser;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [MS_BITS-1:0]        cfg_data;

  click_scoreboard sb;
  int              cycles;
  int              rx_tick;
  int              items_sent;
  int              burst_left;
  logic [31:0]     t_ms;
  logic [31:0]     t_edge;

  multi_click_hold_button_detector u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver back-pressure: cycles through free-running, light, heavy and periodic stalls
  always @(negedge clk) begin
    rx_tick++;
    case ((rx_tick / 97) % 4)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = ($urandom_range(0, 3) != 0);
      2: m_axis_tready = ($urandom_range(0, 5) == 0);
      default: m_axis_tready = (rx_tick % 3 != 0);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_request(req_type_t'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[32]);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(event_kind_t'(m_axis_tuser), m_axis_tdata[7:0]);
    end
  end

  // called and returns at a falling edge
  task automatic send_request(req_type_t rt, logic [31:0] now, bit pin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {7'b0, pin, now};
    s_axis_tuser  = rt;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
    if (rt == REQ_EDGE) t_edge = now;
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // hold off requests until every outstanding result is back
  task automatic drain();
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_setting(bit act, int unsigned sil, int unsigned rs, int unsigned hd,
                               int unsigned rw);
    drain();
    write_reg(CFG_ACTIVE_HIGH, {15'b0, act});
    write_reg(CFG_SILENCE, sil[15:0]);
    write_reg(CFG_RESTART, rs[15:0]);
    write_reg(CFG_HOLD, hd[15:0]);
    write_reg(CFG_REPORT_WAIT, rw[15:0]);
  endtask

  // offsets clustered round a threshold, so both sides of each compare get hit
  function automatic logic [31:0] near(logic [15:0] th);
    logic [31:0] w;
    w = {16'b0, th};
    case ($urandom_range(0, 5))
      0: return (w == 0) ? w : w - 1;
      1: return w;
      2: return w + 1;
      3: return $urandom_range(0, w / 2);
      4: return $urandom_range(0, 2 * w + 10);
      default: return $urandom_range(0, 60);
    endcase
  endfunction

  // polls at non-decreasing offsets from base
  task automatic poll_run(logic [31:0] base, logic [15:0] th, int n, bit pin);
    logic [31:0] off;
    logic [31:0] cur;
    cur = t_ms - base;
    repeat (n) begin
      off = near(th);
      if (off > cur) cur = off;
      t_ms = base + cur;
      send_request(REQ_POLL, t_ms, pin);
    end
  endtask

  // a press/release gesture of one or more clicks, with bounce and polls throughout
  task automatic gesture();
    bit on;
    int presses;
    on      = sb.active_high;
    presses = $urandom_range(1, 4);
    for (int p = 0; p < presses; p++) begin
      t_ms += (p == 0) ? near(sb.restart_ms) : near(sb.silence_ms) + near(sb.report_wait_ms) / 4;
      send_request(REQ_EDGE, t_ms, on);
      repeat ($urandom_range(0, 2)) begin
        t_ms += $urandom_range(0, sb.silence_ms);
        send_request(REQ_EDGE, t_ms, $urandom_range(0, 1));
      end
      poll_run(t_edge, sb.hold_ms, $urandom_range(0, 3), on);
      t_ms += near(sb.silence_ms);
      send_request(REQ_EDGE, t_ms, !on);
      if ($urandom_range(0, 3) == 0) begin
        t_ms += $urandom_range(0, sb.silence_ms);
        send_request(REQ_EDGE, t_ms, on);
        t_ms += $urandom_range(0, sb.silence_ms);
        send_request(REQ_EDGE, t_ms, !on);
      end
      poll_run(t_edge, sb.report_wait_ms, $urandom_range(0, 1), !on);
    end
    poll_run(t_edge, sb.report_wait_ms, $urandom_range(1, 2), !on);
    if ($urandom_range(0, 2) == 0) poll_run(t_edge, sb.restart_ms, 1, $urandom_range(0, 1));
  endtask

  task automatic random_run(int n);
    int target;
    logic [31:0] stamp;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          stamp = $urandom;
          send_request(req_type_t'($urandom_range(0, 1)), stamp, $urandom_range(0, 1));
          if ($urandom_range(0, 1) == 0) t_ms = stamp;
        end
      end else begin
        gesture();
      end
      if ($urandom_range(0, 29) == 0) drain();
    end
  endtask

  initial begin
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_ACTIVE_HIGH;
    cfg_data      = '0;
    cycles        = 0;
    rx_tick       = 0;
    items_sent    = 0;
    burst_left    = 0;
    t_ms          = '0;
    t_edge        = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset settings: bounce, clicks, double click, hold, start-over, time wrap
    send_request(REQ_POLL, 32'd0, 1'b0);
    send_request(REQ_EDGE, 32'd100, 1'b1);
    send_request(REQ_EDGE, 32'd110, 1'b0);
    send_request(REQ_EDGE, 32'd200, 1'b0);
    send_request(REQ_POLL, 32'd500, 1'b0);
    send_request(REQ_POLL, 32'd601, 1'b0);
    send_request(REQ_EDGE, 32'd700, 1'b1);
    send_request(REQ_EDGE, 32'd800, 1'b0);
    send_request(REQ_EDGE, 32'd900, 1'b1);
    send_request(REQ_EDGE, 32'd1000, 1'b0);
    send_request(REQ_POLL, 32'd1401, 1'b0);
    send_request(REQ_EDGE, 32'd2000, 1'b1);
    send_request(REQ_POLL, 32'd2799, 1'b1);
    send_request(REQ_POLL, 32'd2800, 1'b1);
    send_request(REQ_POLL, 32'd3000, 1'b1);
    send_request(REQ_EDGE, 32'd3100, 1'b0);
    send_request(REQ_POLL, 32'd3200, 1'b0);
    send_request(REQ_EDGE, 32'd5000, 1'b0);
    send_request(REQ_EDGE, 32'd6001, 1'b1);
    send_request(REQ_EDGE, 32'd6100, 1'b0);
    send_request(REQ_POLL, 32'd7100, 1'b0);
    send_request(REQ_POLL, 32'hFFFF_FFFF, 1'b0);
    send_request(REQ_EDGE, 32'hFFFF_FFF0, 1'b1);
    send_request(REQ_EDGE, 32'h0000_0020, 1'b0);
    send_request(REQ_EDGE, 32'h0000_0060, 1'b0);
    send_request(REQ_POLL, 32'h0000_01F1, 1'b0);
    t_ms = 32'h0000_0200;

    random_run(50);
    apply_setting(1'b0, 20, 600, 300, 150);
    random_run(50);
    apply_setting(1'b1, 0, 0, 0, 0);
    random_run(40);
    apply_setting(1'b0, 65535, 65535, 65535, 65535);
    random_run(40);

    // counter full: a long run of releases with no report in between
    apply_setting(1'b1, 0, 65535, 65535, 10);
    repeat (260) begin
      t_ms += 1;
      send_request(REQ_EDGE, t_ms, 1'b0);
    end
    t_ms += 20;
    send_request(REQ_POLL, t_ms, 1'b0);
    random_run(20);

    repeat (2) begin
      apply_setting($urandom_range(0, 1), $urandom_range(0, 100), $urandom_range(0, 3000),
                    $urandom_range(0, 2000), $urandom_range(0, 1500));
      random_run(40);
    end

    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### multi_click_hold_button_detector.f
sv/mchb_pkg.sv
sv/mchb_step.sv
sv/multi_click_hold_button_detector.sv
sv/mchb_checker.sv
tb/tb_multi_click_hold_button_detector.sv
